@@ design/bchs_pkg.sv @@
// bchs_pkg: types, codes and reset values for the brew cycle heater sequencer
// no dependencies; used by brew_cycle_heater_sequencer

package bchs_pkg;

  // item kinds carried on the input tuser
  typedef enum logic [2:0] {
    MODE_TICK         = 3'd0,
    MODE_START_ABORT  = 3'd1,
    MODE_PUMP         = 3'd2,
    MODE_SOLENOID     = 3'd3,
    MODE_WARMER       = 3'd4,
    MODE_HEATER       = 3'd5,
    MODE_ALL_OFF      = 3'd6,
    MODE_CLEAR_PULSES = 3'd7
  } mode_e;

  // cycle phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_PREHEAT = 4'b0010,
    PH_BREW    = 4'b0100,
    PH_FINISH  = 4'b1000
  } phase_e;

  localparam logic [1:0] PHASE_CODE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_CODE_PREHEAT = 2'd1;
  localparam logic [1:0] PHASE_CODE_BREW    = 2'd2;
  localparam logic [1:0] PHASE_CODE_FINISH  = 2'd3;

  typedef struct packed {
    logic warmer;
    logic solenoid;
    logic heater;
    logic pump;
  } relays_t;

  // register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 20;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_TEMP     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HYSTERESIS      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_BREW_TEMP   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BREW_TIME       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PREHEAT_TIMEOUT = 3'd4;

  localparam logic [9:0]  TARGET_TEMP_RST     = 10'd930;
  localparam logic [6:0]  HYSTERESIS_RST      = 7'd20;
  localparam logic [9:0]  MIN_BREW_TEMP_RST   = 10'd850;
  localparam logic [15:0] BREW_TIME_RST       = 16'd25000;
  localparam logic [19:0] PREHEAT_TIMEOUT_RST = 20'd60000;

  localparam int unsigned OutTimerW = 20;
  localparam logic [OutTimerW-1:0] OUT_TIMER_MAX = 20'hFFFFF;

  function automatic logic [1:0] phase_code(phase_e ph);
    logic [1:0] code;
    unique case (ph)
      PH_IDLE:    code = PHASE_CODE_IDLE;
      PH_PREHEAT: code = PHASE_CODE_PREHEAT;
      PH_BREW:    code = PHASE_CODE_BREW;
      PH_FINISH:  code = PHASE_CODE_FINISH;
      default:    code = PHASE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

@@ design/brew_cycle_heater_sequencer.sv @@
// brew_cycle_heater_sequencer: four-phase heater, pump, valve and warmer sequencer
// depends on bchs_pkg
//
// usage: each input item on s_axis is either a tick (temperature, elapsed
// milliseconds, flow pulses) or a command selected by s_axis_tuser. every
// item yields one result item on m_axis showing relays, phase, phase timer
// and pulse total after that item. configuration registers are written over
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only while no item
// is in flight, as the block itself does not enforce this. the input item is
// captured in the input register; the state update and the result register load
// then happen in the same cycle, once m_axis can advance. throughput is one item
// per cycle while m_axis does not stall, bounded by the single state update stage.
// when m_axis stalls, the input register still fills, so one more item is taken
// before s_axis_tready drops; nothing is lost or repeated.
// reset clears the phase to idle, relays off, timer and pulse total to zero,
// and loads the default register values; no clearing pass is needed.

module brew_cycle_heater_sequencer #(
  parameter int unsigned TIMER_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // temperature[12:0], elapsed_ms[22:13], flow_pulses[30:23], zero[31]
  input  logic [31:0] s_axis_tdata,
  // mode[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pump_on[0], heater_on[1], solenoid_on[2], warmer_on[3], phase[5:4],
  // phase_elapsed_ms[25:6], pulse_total[57:26], zero[63:58]
  output logic [63:0] m_axis_tdata
);

  localparam int unsigned SumW = TIMER_BITS + 1;
  localparam int unsigned CmpW = (TIMER_BITS > 20) ? TIMER_BITS : 20;

  // configuration
  logic [9:0]  target_q;
  logic [6:0]  hyst_q;
  logic [9:0]  min_brew_q;
  logic [15:0] brew_time_q;
  logic [19:0] preheat_to_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= bchs_pkg::TARGET_TEMP_RST;
      hyst_q       <= bchs_pkg::HYSTERESIS_RST;
      min_brew_q   <= bchs_pkg::MIN_BREW_TEMP_RST;
      brew_time_q  <= bchs_pkg::BREW_TIME_RST;
      preheat_to_q <= bchs_pkg::PREHEAT_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bchs_pkg::CFG_TARGET_TEMP:     target_q     <= cfg_data_i[9:0];
        bchs_pkg::CFG_HYSTERESIS:      hyst_q       <= cfg_data_i[6:0];
        bchs_pkg::CFG_MIN_BREW_TEMP:   min_brew_q   <= cfg_data_i[9:0];
        bchs_pkg::CFG_BREW_TIME:       brew_time_q  <= cfg_data_i[15:0];
        bchs_pkg::CFG_PREHEAT_TIMEOUT: preheat_to_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  logic in_valid_q;
  logic out_valid_q;
  logic advance;
  logic process;

  assign advance       = !out_valid_q || m_axis_tready;
  assign process       = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;

  // input register
  bchs_pkg::mode_e    mode_q;
  logic signed [12:0] temp_q;
  logic [9:0]         elapsed_q;
  logic [7:0]         flow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mode_q    <= bchs_pkg::mode_e'(s_axis_tuser);
      temp_q    <= $signed(s_axis_tdata[12:0]);
      elapsed_q <= s_axis_tdata[22:13];
      flow_q    <= s_axis_tdata[30:23];
    end
  end

  // sequencer state
  bchs_pkg::phase_e        phase_q, phase_d;
  bchs_pkg::relays_t       relay_q, relay_d;
  logic [TIMER_BITS-1:0]   timer_q, timer_d;
  logic [31:0]             pulse_q, pulse_d;

  logic [SumW-1:0]         timer_sum;
  logic [TIMER_BITS-1:0]   timer_tick;
  logic signed [12:0]      band_lo;
  logic signed [12:0]      band_hi;
  logic signed [12:0]      min_brew_s;

  assign timer_sum  = {1'b0, timer_q} + SumW'(elapsed_q);
  assign timer_tick = timer_sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : timer_sum[TIMER_BITS-1:0];
  assign band_lo    = $signed({3'b000, target_q}) - $signed({6'b000000, hyst_q});
  assign band_hi    = $signed({3'b000, target_q}) + $signed({6'b000000, hyst_q});
  assign min_brew_s = $signed({3'b000, min_brew_q});

  always_comb begin
    phase_d = phase_q;
    relay_d = relay_q;
    timer_d = timer_q;
    pulse_d = pulse_q;
    if (process) begin
      case (mode_q)
        bchs_pkg::MODE_TICK: begin
          pulse_d = pulse_q + 32'(flow_q);
          timer_d = timer_tick;
          if (phase_q == bchs_pkg::PH_PREHEAT || phase_q == bchs_pkg::PH_BREW) begin
            if (temp_q < band_lo) begin
              relay_d.heater = 1'b1;
            end else if (temp_q > band_hi) begin
              relay_d.heater = 1'b0;
            end
          end
          unique case (phase_q)
            bchs_pkg::PH_PREHEAT: begin
              if (temp_q >= min_brew_s) begin
                phase_d          = bchs_pkg::PH_BREW;
                timer_d          = '0;
                relay_d.pump     = 1'b1;
                relay_d.solenoid = 1'b1;
              end else if (CmpW'(timer_tick) > CmpW'(preheat_to_q)) begin
                phase_d = bchs_pkg::PH_IDLE;
                timer_d = '0;
                relay_d = '0;
              end
            end
            bchs_pkg::PH_BREW: begin
              if (CmpW'(timer_tick) >= CmpW'(brew_time_q)) begin
                phase_d = bchs_pkg::PH_FINISH;
                timer_d = '0;
                relay_d = '0;
              end
            end
            bchs_pkg::PH_FINISH: begin
              phase_d = bchs_pkg::PH_IDLE;
              timer_d = '0;
            end
            default: ;
          endcase
        end
        bchs_pkg::MODE_START_ABORT: begin
          timer_d = '0;
          if (phase_q == bchs_pkg::PH_IDLE) begin
            phase_d        = bchs_pkg::PH_PREHEAT;
            pulse_d        = '0;
            relay_d.warmer = 1'b1;
            relay_d.heater = 1'b1;
          end else begin
            phase_d = bchs_pkg::PH_IDLE;
            relay_d = '0;
          end
        end
        bchs_pkg::MODE_PUMP:         relay_d.pump     = !relay_q.pump;
        bchs_pkg::MODE_SOLENOID:     relay_d.solenoid = !relay_q.solenoid;
        bchs_pkg::MODE_WARMER:       relay_d.warmer   = !relay_q.warmer;
        bchs_pkg::MODE_HEATER:       relay_d.heater   = !relay_q.heater;
        bchs_pkg::MODE_ALL_OFF:      relay_d          = '0;
        bchs_pkg::MODE_CLEAR_PULSES: pulse_d          = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bchs_pkg::PH_IDLE;
      relay_q <= '0;
      timer_q <= '0;
      pulse_q <= '0;
    end else begin
      phase_q <= phase_d;
      relay_q <= relay_d;
      timer_q <= timer_d;
      pulse_q <= pulse_d;
    end
  end

  // result register
  logic [CmpW-1:0] timer_ext;
  logic [19:0]     timer_out;
  logic [63:0]     tdata_d;
  logic [63:0]     tdata_q;

  assign timer_ext = CmpW'(timer_d);
  assign timer_out = (timer_ext > CmpW'(bchs_pkg::OUT_TIMER_MAX)) ?
                     bchs_pkg::OUT_TIMER_MAX : timer_ext[19:0];
  assign tdata_d   = {6'b000000, pulse_d, timer_out, bchs_pkg::phase_code(phase_d),
                      relay_d.warmer, relay_d.solenoid, relay_d.heater, relay_d.pump};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      tdata_q <= tdata_d;
    end
  end

  assign m_axis_tdata = tdata_q;

  // checks
  a_phase_change_clears_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && phase_d != phase_q) |=> (timer_q == '0))
    else $error("phase change did not clear timer");

  a_brew_stop_relays_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && phase_q == bchs_pkg::PH_BREW && phase_d == bchs_pkg::PH_FINISH)
    |=> (relay_q == '0))
    else $error("relays on after brew stop");

  a_stall_only_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without output backpressure");

  a_idle_state_kept_on_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && mode_q != bchs_pkg::MODE_TICK && mode_q != bchs_pkg::MODE_START_ABORT)
    |=> $stable(phase_q))
    else $error("command other than tick or start changed phase");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for brew_cycle_heater_sequencer, a directed table then
// random brew cycles under four idle/stall mixes, checked against an in-bench predictor
// depends on bchs_pkg and the sequencer rtl

module tb_top;

  localparam int unsigned TimerBits = 20;
  localparam longint unsigned TimerMax = (longint'(1) << TimerBits) - 1;
  localparam int unsigned HangLimit = 4000;
  localparam int unsigned PhaseItems = 140;
  localparam logic [bchs_pkg::CfgIdxW-1:0] CFG_UNMAPPED = 3'd6;

  typedef struct packed {
    logic [5:0]        pad;
    logic [31:0]       pulse_total;
    logic [19:0]       elapsed;
    logic [1:0]        phase;
    bchs_pkg::relays_t relays;
  } status_t;

  typedef struct {
    bchs_pkg::mode_e mode;
    int              temp;
    int              elapsed;
    int              pulses;
    bit              literal;
    logic [3:0]      relays;
    logic [1:0]      phase;
    int unsigned     timer;
    int unsigned     pulse_total;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [19:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // temperature[12:0], elapsed_ms[22:13], flow_pulses[30:23], zero[31]
  logic [31:0] s_axis_tdata = '0;
  // mode[2:0]
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // pump_on[0], heater_on[1], solenoid_on[2], warmer_on[3], phase[5:4],
  // phase_elapsed_ms[25:6], pulse_total[57:26], zero[63:58]
  logic [63:0] m_axis_tdata;

  // predictor copy of registers and state
  logic [9:0]           target_temp;
  logic [6:0]           hysteresis;
  logic [9:0]           min_brew;
  logic [15:0]          brew_len;
  logic [19:0]          preheat_limit;
  bchs_pkg::relays_t    relays;
  logic [1:0]           cycle_phase;
  logic [TimerBits-1:0] phase_timer;
  logic [31:0]          pulse_count;

  status_t     pending_status_q[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;

  directed_row_t directed_rows [25] = '{
    '{bchs_pkg::MODE_TICK,          0,    0,   0, 1'b1,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_TICK,      -4096, 1023, 255, 1'b1,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    1023, 255},
    '{bchs_pkg::MODE_CLEAR_PULSES, 1234, 77,  99, 1'b1,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    1023, 0},
    '{bchs_pkg::MODE_PUMP,         -1, 1023, 255, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_SOLENOID,      0,    0,   0, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_WARMER,     4095,  512, 128, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_HEATER,     2500,    0,   1, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_ALL_OFF,    -500, 1000, 255, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_TICK,       4095,    0,   7, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_START_ABORT, 100, 1000, 200, 1'b1,
      4'b1010, bchs_pkg::PHASE_CODE_PREHEAT, 0,    0},
    '{bchs_pkg::MODE_TICK,        849, 1000,   3, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_HEATER,        0,    0,   0, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_TICK,        800, 1000,  10, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_TICK,        850,  500,  20, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_TICK,        960, 1000,  30, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_TICK,        930, 1000,  40, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_TICK,        909, 1000,  50, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_TICK,        950, 1000,  60, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_TICK,        951, 1000,  70, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_START_ABORT,   0,    0,   0, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_START_ABORT,   0,    0,   0, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_TICK,         -1, 1000, 255, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_CLEAR_PULSES,  0,    0,   0, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_ALL_OFF,       0,    0,   0, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0},
    '{bchs_pkg::MODE_START_ABORT,   0,    0,   0, 1'b0,
      4'b0000, bchs_pkg::PHASE_CODE_IDLE,    0,    0}
  };

  brew_cycle_heater_sequencer #(.TIMER_BITS(TimerBits)) dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic status_t advance_sequencer(bchs_pkg::mode_e m, logic [12:0] traw,
                                                logic [9:0] e, logic [7:0] p);
    int              tv;
    int              band_lo;
    int              band_hi;
    longint unsigned sum;
    status_t         s;
    tv = $signed(traw);
    band_lo = int'(target_temp) - int'(hysteresis);
    band_hi = int'(target_temp) + int'(hysteresis);
    case (m)
      bchs_pkg::MODE_TICK: begin
        pulse_count = pulse_count + p;
        sum = longint'(phase_timer) + longint'(e);
        phase_timer = (sum > TimerMax) ? TimerBits'(TimerMax) : TimerBits'(sum);
        if (cycle_phase == bchs_pkg::PHASE_CODE_PREHEAT ||
            cycle_phase == bchs_pkg::PHASE_CODE_BREW) begin
          if (tv < band_lo) relays.heater = 1'b1;
          else if (tv > band_hi) relays.heater = 1'b0;
        end
        case (cycle_phase)
          bchs_pkg::PHASE_CODE_PREHEAT: begin
            if (tv >= int'(min_brew)) begin
              cycle_phase = bchs_pkg::PHASE_CODE_BREW;
              phase_timer = '0;
              relays.pump = 1'b1;
              relays.solenoid = 1'b1;
            end else if (phase_timer > preheat_limit) begin
              relays = '0;
              cycle_phase = bchs_pkg::PHASE_CODE_IDLE;
              phase_timer = '0;
            end
          end
          bchs_pkg::PHASE_CODE_BREW: begin
            if (phase_timer >= brew_len) begin
              relays = '0;
              cycle_phase = bchs_pkg::PHASE_CODE_FINISH;
              phase_timer = '0;
            end
          end
          bchs_pkg::PHASE_CODE_FINISH: begin
            cycle_phase = bchs_pkg::PHASE_CODE_IDLE;
            phase_timer = '0;
          end
          default: ;
        endcase
      end
      bchs_pkg::MODE_START_ABORT: begin
        if (cycle_phase == bchs_pkg::PHASE_CODE_IDLE) begin
          pulse_count = '0;
          relays.warmer = 1'b1;
          relays.heater = 1'b1;
          cycle_phase = bchs_pkg::PHASE_CODE_PREHEAT;
        end else begin
          relays = '0;
          cycle_phase = bchs_pkg::PHASE_CODE_IDLE;
        end
        phase_timer = '0;
      end
      bchs_pkg::MODE_PUMP:     relays.pump = ~relays.pump;
      bchs_pkg::MODE_SOLENOID: relays.solenoid = ~relays.solenoid;
      bchs_pkg::MODE_WARMER:   relays.warmer = ~relays.warmer;
      bchs_pkg::MODE_HEATER:   relays.heater = ~relays.heater;
      bchs_pkg::MODE_ALL_OFF:  relays = '0;
      default:                 pulse_count = '0;
    endcase
    s.pad = '0;
    s.pulse_total = pulse_count;
    s.elapsed = (longint'(phase_timer) > longint'(bchs_pkg::OUT_TIMER_MAX)) ?
                bchs_pkg::OUT_TIMER_MAX : 20'(phase_timer);
    s.phase = cycle_phase;
    s.relays = relays;
    return s;
  endfunction

  function automatic void log_mismatch(string why, status_t want, status_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: want relays=%b phase=%0d ms=%0d pulses=%0d pad=%h",
               $realtime, why, want.relays, want.phase, want.elapsed, want.pulse_total,
               want.pad);
    if (mismatches <= 10)
      $display("  got relays=%b phase=%0d ms=%0d pulses=%0d pad=%h",
               got.relays, got.phase, got.elapsed, got.pulse_total, got.pad);
  endfunction

  always @(posedge clk_i) begin
    status_t got;
    status_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_status_q.size() == 0) begin
        log_mismatch("result with no item pending", '0, got);
      end else begin
        want = pending_status_q.pop_front();
        if (got.relays !== want.relays || got.phase !== want.phase ||
            got.elapsed !== want.elapsed || got.pulse_total !== want.pulse_total ||
            got.pad !== want.pad)
          log_mismatch("status mismatch", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HangLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // entered and left just after a falling edge; valid stays high after the item
  task automatic send_item(bchs_pkg::mode_e m, int t, int e, int p,
                           input bit use_lit = 1'b0, input status_t lit = '0);
    status_t want;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = m;
    s_axis_tdata = {1'b0, 8'(p), 10'(e), 13'(t)};
    do @(posedge clk_i); while (!s_axis_tready);
    want = advance_sequencer(m, 13'(t), 10'(e), 8'(p));
    pending_status_q.push_back(use_lit ? lit : want);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending_status_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [bchs_pkg::CfgIdxW-1:0] idx, logic [19:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    case (idx)
      bchs_pkg::CFG_TARGET_TEMP:     target_temp = data[9:0];
      bchs_pkg::CFG_HYSTERESIS:      hysteresis = data[6:0];
      bchs_pkg::CFG_MIN_BREW_TEMP:   min_brew = data[9:0];
      bchs_pkg::CFG_BREW_TIME:       brew_len = data[15:0];
      bchs_pkg::CFG_PREHEAT_TIMEOUT: preheat_limit = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_config(int tt, int hy, int mb, int bt, int pt);
    write_reg(bchs_pkg::CFG_TARGET_TEMP, 20'(tt));
    write_reg(bchs_pkg::CFG_HYSTERESIS, 20'(hy));
    write_reg(bchs_pkg::CFG_MIN_BREW_TEMP, 20'(mb));
    write_reg(bchs_pkg::CFG_BREW_TIME, 20'(bt));
    write_reg(bchs_pkg::CFG_PREHEAT_TIMEOUT, 20'(pt));
  endtask

  function automatic int temp_in(int lo, int hi);
    if (lo < -4096) lo = -4096;
    if (hi > 4095) hi = 4095;
    if (hi <= lo) return hi;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic send_noise();
    send_item(bchs_pkg::mode_e'($urandom_range(7)), temp_in(-4096, 4095),
              $urandom_range(1023), $urandom_range(255));
  endtask

  task automatic maybe_command(int pct);
    if ($urandom_range(99) < pct)
      send_item(bchs_pkg::mode_e'($urandom_range(7, 2)), temp_in(-4096, 4095),
                $urandom_range(1023), $urandom_range(255));
  endtask

  // start, preheat, brew and finish with random content
  task automatic run_cycle();
    int guard;
    int cold;
    int band_lo;
    int band_hi;
    cold = int'(min_brew) - 1;
    band_lo = int'(target_temp) - int'(hysteresis) - 30;
    band_hi = int'(target_temp) + int'(hysteresis) + 30;
    if (cycle_phase != bchs_pkg::PHASE_CODE_IDLE)
      send_item(bchs_pkg::MODE_START_ABORT, temp_in(-4096, 4095), 0, $urandom_range(255));
    send_item(bchs_pkg::MODE_START_ABORT, temp_in(-4096, 4095), $urandom_range(1023),
              $urandom_range(255));
    guard = $urandom_range(6);
    while (guard > 0 && cycle_phase == bchs_pkg::PHASE_CODE_PREHEAT) begin
      send_item(bchs_pkg::MODE_TICK, temp_in(cold - 300, cold), $urandom_range(1023),
                $urandom_range(255));
      maybe_command(10);
      guard--;
    end
    if ($urandom_range(99) < 25) begin
      guard = 40;
      while (guard > 0 && cycle_phase == bchs_pkg::PHASE_CODE_PREHEAT) begin
        send_item(bchs_pkg::MODE_TICK, temp_in(cold - 300, cold),
                  $urandom_range(1023, 900), $urandom_range(255));
        guard--;
      end
    end
    if (cycle_phase == bchs_pkg::PHASE_CODE_PREHEAT)
      send_item(bchs_pkg::MODE_TICK, temp_in(cold + 1, cold + 200), $urandom_range(1023),
                $urandom_range(255));
    guard = 120;
    while (guard > 0 && cycle_phase == bchs_pkg::PHASE_CODE_BREW) begin
      send_item(bchs_pkg::MODE_TICK, temp_in(band_lo, band_hi), $urandom_range(1023, 300),
                $urandom_range(255));
      maybe_command(10);
      if ($urandom_range(99) < 2)
        send_item(bchs_pkg::MODE_START_ABORT, temp_in(-4096, 4095), 0, 0);
      guard--;
    end
    if (cycle_phase == bchs_pkg::PHASE_CODE_FINISH) begin
      maybe_command(30);
      send_item(bchs_pkg::MODE_TICK, temp_in(-4096, 4095), $urandom_range(1023),
                $urandom_range(255));
    end
  endtask

  task automatic random_phase(int src_pct, int sink_pct);
    int unsigned first;
    int unsigned r;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    first = items_sent;
    while (items_sent - first < PhaseItems) begin
      r = $urandom_range(99);
      if (r < 70) begin
        run_cycle();
      end else if (r < 85) begin
        send_noise();
      end else begin
        send_item(bchs_pkg::MODE_START_ABORT, 0, 0, 0);
        repeat ($urandom_range(3)) send_noise();
        send_item(bchs_pkg::MODE_START_ABORT, temp_in(-4096, 4095), 0, 0);
      end
    end
  endtask

  initial begin
    status_t lit;
    target_temp = bchs_pkg::TARGET_TEMP_RST;
    hysteresis = bchs_pkg::HYSTERESIS_RST;
    min_brew = bchs_pkg::MIN_BREW_TEMP_RST;
    brew_len = bchs_pkg::BREW_TIME_RST;
    preheat_limit = bchs_pkg::PREHEAT_TIMEOUT_RST;
    relays = '0;
    cycle_phase = bchs_pkg::PHASE_CODE_IDLE;
    phase_timer = '0;
    pulse_count = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[k]) begin
      lit = '{pad: '0, pulse_total: directed_rows[k].pulse_total,
              elapsed: 20'(directed_rows[k].timer), phase: directed_rows[k].phase,
              relays: bchs_pkg::relays_t'(directed_rows[k].relays)};
      send_item(directed_rows[k].mode, directed_rows[k].temp, directed_rows[k].elapsed,
                directed_rows[k].pulses, directed_rows[k].literal, lit);
    end

    drain();
    load_config(1000, 100, 1000, 5000, 1000);
    random_phase(0, 0);

    drain();
    load_config(700, 0, 0, 60000, 600000);
    random_phase(52, 0);

    drain();
    load_config($urandom_range(1000, 700), $urandom_range(100), $urandom_range(1000),
                $urandom_range(60000, 5000), $urandom_range(20000, 1000));
    random_phase(0, 52);

    // registers at or past their ranges, upper bits of the write data dropped
    drain();
    load_config(20'hFFC00, 127, 1023, 65535, 20'hFFFFF);
    write_reg(CFG_UNMAPPED, 20'($urandom));
    random_phase(17, 17);

    drain();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && pending_status_q.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

@@ sim.f @@
design/bchs_pkg.sv
design/brew_cycle_heater_sequencer.sv
verif/tb_top.sv
